// File: rtl/brdf_pkg.sv
// Package for the best rebase delta finder: sizes, codes and word types.
// No dependencies.
package brdf_pkg;
  localparam int ENTRY_DEPTH = 256;
  localparam int TARGET_DEPTH = 256;
  localparam int SHIFT_DEPTH = 1024;
  localparam int REPORT_LIMIT = 16;
  localparam int EAW = $clog2(ENTRY_DEPTH);
  localparam int TAW = $clog2(TARGET_DEPTH);
  localparam int SAW = $clog2(SHIFT_DEPTH);
  localparam int ECW = $clog2(ENTRY_DEPTH + 1);
  localparam int TCW = $clog2(TARGET_DEPTH + 1);
  localparam int SCW = $clog2(SHIFT_DEPTH + 1);
  localparam int RCW = $clog2(REPORT_LIMIT + 1);

  localparam logic [1:0] REQ_ENTRY = 2'd0;
  localparam logic [1:0] REQ_TARGET = 2'd1;
  localparam logic [1:0] REQ_ANALYZE = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_BEST = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [2:0] CFG_ADDR_BITS = 3'd0;
  localparam logic [2:0] CFG_ENTRY_LOW = 3'd1;
  localparam logic [2:0] CFG_ENTRY_HIGH = 3'd2;
  localparam logic [2:0] CFG_TARGET_LOW = 3'd3;
  localparam logic [2:0] CFG_TARGET_HIGH = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  load_status;
    logic [63:0] best_shift;
    logic [8:0]  match_count;
    logic [8:0]  window_entry_count;
    logic        report_truncated;
    logic        candidates_dropped;
    logic        last_result;
  } out_word_t;
endpackage

// File: rtl/brdf_ram.sv
// Generic single-port-write, one-read synchronous RAM, registered read data.
// No dependencies.
module brdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/best_rebase_delta_finder.sv
// Load: searches the set for the address and inserts it if absent and there is room;
// one strobe. Clear: strobe in the cycle after the accept. Analyze: for each in-window
// entry and in-window target, searches the stored shifts and stores a new difference;
// then counts matches per shift; then scans stored shifts per reported word, one strobe per word.
// One request at a time; busy drops with the last strobe. Reset (rst, synchronous)
// empties both sets and restores register defaults. The receiver cannot stall.
module best_rebase_delta_finder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  brdf_pkg::in_word_t  in_word,
  output logic                result_valid,
  output brdf_pkg::out_word_t result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import brdf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_CHK, S_LD_WR,
    S_PE_RD, S_PE_W, S_PT_RD, S_PT_W, S_PS_RD, S_PS_CHK, S_PS_NEXT,
    S_ME_RD, S_ME_W, S_MT_RD, S_MT_W, S_MT_CHK, S_M_NEXT,
    S_R_RD, S_R_W, S_R_CHK, S_R_EMIT
  } state_t;

  state_t state;
  logic [6:0]  address_bits;
  logic [63:0] ew_lo, ew_hi, tw_lo, tw_hi;
  logic [ECW-1:0] entry_count;
  logic [TCW-1:0] target_count;
  logic [SCW-1:0] shift_count;
  logic [1:0] req;
  logic [63:0] addr;
  logic [ECW-1:0] ei;
  logic [TCW-1:0] tj;
  logic [SCW-1:0] si;
  logic [63:0] e_val, cur_shift, diff, pick, prev;
  logic [8:0]  wcount, best, mcnt;
  logic [SCW-1:0] nbest;
  logic [RCW-1:0] k;
  logic dropped, found, got, have_prev;

  logic        e_we, t_we, s_we, m_we;
  logic [EAW-1:0] e_ra;
  logic [TAW-1:0] t_ra;
  logic [SAW-1:0] s_ra, s_wa;
  logic [63:0] e_rd, t_rd, s_rd, s_wd;
  logic [8:0]  m_rd;

  logic [63:0] mask;
  logic [63:0] sum_m;
  logic ld_ent, e_in, t_in;
  logic ld_hit, emit;

  always_comb begin
    if (address_bits >= 7'd64) mask = '1;
    else if (address_bits == 7'd0) mask = 64'd1;
    else mask = (64'd1 << address_bits[5:0]) - 64'd1;
  end

  assign ld_ent = (req == REQ_ENTRY);
  assign e_in = (e_rd >= ew_lo) && (e_rd <= ew_hi);
  assign t_in = (t_rd >= tw_lo) && (t_rd <= tw_hi);
  assign sum_m = (e_val + cur_shift) & mask;
  assign ld_hit = ((ld_ent ? e_rd : t_rd) == addr);
  assign emit = (state == S_IDLE && start && in_word.req_type == REQ_CLEAR) ||
                (state == S_LD_CHK && ld_hit) || (state == S_LD_WR) ||
                (state == S_R_EMIT);

  brdf_ram #(.WIDTH(64), .DEPTH(ENTRY_DEPTH)) u_entry (
    .clk(clk), .we(e_we), .waddr(entry_count[EAW-1:0]), .wdata(addr),
    .raddr(e_ra), .rdata(e_rd));
  brdf_ram #(.WIDTH(64), .DEPTH(TARGET_DEPTH)) u_target (
    .clk(clk), .we(t_we), .waddr(target_count[TAW-1:0]), .wdata(addr),
    .raddr(t_ra), .rdata(t_rd));
  brdf_ram #(.WIDTH(64), .DEPTH(SHIFT_DEPTH)) u_shift (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  brdf_ram #(.WIDTH(9), .DEPTH(SHIFT_DEPTH)) u_match (
    .clk(clk), .we(m_we), .waddr(si[SAW-1:0]), .wdata(mcnt), .raddr(s_ra),
    .rdata(m_rd));

  always_comb begin
    e_we = 1'b0;
    t_we = 1'b0;
    s_we = 1'b0;
    m_we = 1'b0;
    s_wa = shift_count[SAW-1:0];
    s_wd = diff;
    e_ra = ei[EAW-1:0];
    t_ra = tj[TAW-1:0];
    s_ra = si[SAW-1:0];
    if (state == S_LD_WR) begin
      e_we = ld_ent && (entry_count < ECW'(ENTRY_DEPTH));
      t_we = !ld_ent && (target_count < TCW'(TARGET_DEPTH));
    end
    if (state == S_PS_NEXT && !found && shift_count < SCW'(SHIFT_DEPTH)) s_we = 1'b1;
    if (state == S_MT_CHK && tj == TCW'(0)) m_we = 1'b0;
    if (state == S_M_NEXT) m_we = 1'b1;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      address_bits <= 7'd32;
      ew_lo <= '0;
      ew_hi <= '1;
      tw_lo <= '0;
      tw_hi <= '1;
      entry_count <= '0;
      target_count <= '0;
      shift_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDR_BITS:   address_bits <= cfg_data[6:0];
          CFG_ENTRY_LOW:   ew_lo <= cfg_data;
          CFG_ENTRY_HIGH:  ew_hi <= cfg_data;
          CFG_TARGET_LOW:  tw_lo <= cfg_data;
          CFG_TARGET_HIGH: tw_hi <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= in_word.req_type;
            addr <= in_word.address_value;
            ei <= '0;
            tj <= '0;
            case (in_word.req_type)
              REQ_ENTRY, REQ_TARGET: begin
                result <= '0;
                state <= S_LD_RD;
              end
              REQ_ANALYZE: begin
                result <= '0;
                shift_count <= '0;
                wcount <= '0;
                dropped <= 1'b0;
                state <= S_PE_RD;
              end
              default: begin
                entry_count <= '0;
                target_count <= '0;
                shift_count <= '0;
                result <= '{result_kind: KIND_ACK, load_status: ST_INSERTED,
                            best_shift: 64'd0, match_count: 9'd0,
                            window_entry_count: 9'd0, report_truncated: 1'b0,
                            candidates_dropped: 1'b0, last_result: 1'b1};
              end
            endcase
          end
        end
        S_LD_RD: begin
          if (ld_ent ? (ei == entry_count) : (tj == TCW'(target_count))) begin
            state <= S_LD_WR;
          end else begin
            state <= S_LD_CHK;
          end
        end
        S_LD_CHK: begin
          if (ld_hit) begin
            result.load_status <= ST_PRESENT;
            result.last_result <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (ld_ent) ei <= ei + 1'b1;
            else tj <= tj + 1'b1;
            state <= S_LD_RD;
          end
        end
        S_LD_WR: begin
          result.last_result <= 1'b1;
          state <= S_IDLE;
          if (ld_ent ? (entry_count >= ECW'(ENTRY_DEPTH))
                     : (target_count >= TCW'(TARGET_DEPTH))) begin
            result.load_status <= ST_FULL;
          end else begin
            result.load_status <= ST_INSERTED;
            if (ld_ent) entry_count <= entry_count + 1'b1;
            else target_count <= target_count + 1'b1;
          end
        end
        S_PE_RD: begin
          if (ei == entry_count) begin
            si <= '0;
            best <= '0;
            state <= (shift_count == '0) ? S_R_EMIT : S_ME_RD;
          end else begin
            state <= S_PE_W;
          end
        end
        S_PE_W: begin
          e_val <= e_rd;
          tj <= '0;
          if (e_in) begin
            wcount <= wcount + 1'b1;
            state <= S_PT_RD;
          end else begin
            ei <= ei + 1'b1;
            state <= S_PE_RD;
          end
        end
        S_PT_RD: begin
          if (tj == target_count) begin
            ei <= ei + 1'b1;
            state <= S_PE_RD;
          end else begin
            state <= S_PT_W;
          end
        end
        S_PT_W: begin
          diff <= (t_rd - e_val) & mask;
          si <= '0;
          found <= 1'b0;
          if (t_in) state <= S_PS_RD;
          else begin
            tj <= tj + 1'b1;
            state <= S_PT_RD;
          end
        end
        S_PS_RD: begin
          if (si == shift_count) state <= S_PS_NEXT;
          else state <= S_PS_CHK;
        end
        S_PS_CHK: begin
          if (s_rd == diff) begin
            found <= 1'b1;
            state <= S_PS_NEXT;
          end else begin
            si <= si + 1'b1;
            state <= S_PS_RD;
          end
        end
        S_PS_NEXT: begin
          if (!found) begin
            if (shift_count < SCW'(SHIFT_DEPTH)) shift_count <= shift_count + 1'b1;
            else dropped <= 1'b1;
          end
          tj <= tj + 1'b1;
          state <= S_PT_RD;
        end
        S_ME_RD: begin
          ei <= '0;
          mcnt <= '0;
          state <= S_ME_W;
        end
        S_ME_W: begin
          cur_shift <= s_rd;
          if (ei == entry_count) state <= S_M_NEXT;
          else state <= S_MT_RD;
        end
        S_MT_RD: begin
          e_val <= e_rd;
          tj <= '0;
          state <= S_MT_W;
        end
        S_MT_W: begin
          if (tj == target_count) begin
            ei <= ei + 1'b1;
            state <= S_ME_W;
          end else begin
            state <= S_MT_CHK;
          end
        end
        S_MT_CHK: begin
          if (t_rd == sum_m) begin
            mcnt <= mcnt + 1'b1;
            ei <= ei + 1'b1;
            state <= S_ME_W;
          end else begin
            tj <= tj + 1'b1;
            state <= S_MT_W;
          end
        end
        S_M_NEXT: begin
          if (mcnt > best) best <= mcnt;
          if (si + 1'b1 == shift_count) begin
            k <= '0;
            have_prev <= 1'b0;
            nbest <= '0;
            si <= '0;
            got <= 1'b0;
            state <= S_R_RD;
          end else begin
            si <= si + 1'b1;
            state <= S_ME_RD;
          end
        end
        S_R_RD: begin
          state <= S_R_W;
        end
        S_R_W: begin
          if (m_rd == best && (!have_prev || s_rd > prev) && (!got || s_rd < pick)) begin
            pick <= s_rd;
            got <= 1'b1;
          end
          if (!have_prev && m_rd == best) nbest <= nbest + 1'b1;
          state <= S_R_CHK;
        end
        S_R_CHK: begin
          if (si + 1'b1 == shift_count) begin
            si <= '0;
            state <= S_R_EMIT;
          end else begin
            si <= si + 1'b1;
            state <= S_R_RD;
          end
        end
        S_R_EMIT: begin
          result.load_status <= ST_INSERTED;
          result.window_entry_count <= wcount;
          result.candidates_dropped <= dropped;
          if (shift_count == '0) begin
            result.result_kind <= KIND_NONE;
            result.last_result <= 1'b1;
            state <= S_IDLE;
          end else begin
            result.result_kind <= KIND_BEST;
            result.best_shift <= pick;
            result.match_count <= best;
            result.report_truncated <= (nbest > SCW'(REPORT_LIMIT));
            prev <= pick;
            have_prev <= 1'b1;
            got <= 1'b0;
            k <= k + 1'b1;
            if (k + 1'b1 == RCW'(REPORT_LIMIT) || SCW'(k) + 1'b1 == nbest) begin
              result.last_result <= 1'b1;
              state <= S_IDLE;
            end else begin
              result.last_result <= 1'b0;
              state <= S_R_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ecount: assert property (@(posedge clk) disable iff (rst)
    entry_count <= ECW'(ENTRY_DEPTH)) else $error("entry count overflow");
  a_scount: assert property (@(posedge clk) disable iff (rst)
    shift_count <= SCW'(SHIFT_DEPTH)) else $error("shift count overflow");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |-> !busy) else $error("last word while busy");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_word.req_type != REQ_CLEAR |=> busy)
    else $error("request not taken");
`endif
endmodule

// File: test/tb_best_rebase_delta_finder.sv
// Testbench for best_rebase_delta_finder: drives loads, clears and analyze
// requests, and checks every result word against a scoreboard model.
// Depends on brdf_pkg and the best_rebase_delta_finder RTL.
module tb_best_rebase_delta_finder;
  import brdf_pkg::*;

  class rebase_scoreboard;
    logic [6:0]  abits;
    logic [63:0] elo, ehi, tlo, thi;
    logic [63:0] entries[$];
    logic [63:0] targets[$];
    out_word_t   pending[$];
    int          errors;

    function new();
      abits = 7'd32;
      elo = '0;
      ehi = '1;
      tlo = '0;
      thi = '1;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        CFG_ADDR_BITS: abits = d[6:0];
        CFG_ENTRY_LOW: elo = d;
        CFG_ENTRY_HIGH: ehi = d;
        CFG_TARGET_LOW: tlo = d;
        CFG_TARGET_HIGH: thi = d;
        default: ;
      endcase
    endfunction

    function logic [63:0] addr_mask();
      int b;
      b = (abits == 0) ? 1 : abits;
      if (b >= 64) return '1;
      return (64'd1 << b) - 64'd1;
    endfunction

    function void push_ack(logic [1:0] st);
      out_word_t o;
      o = '0;
      o.result_kind = KIND_ACK;
      o.load_status = st;
      o.last_result = 1'b1;
      pending.insert(pending.size(), o);
    endfunction

    function void run_analysis();
      logic [63:0] m, d;
      logic [63:0] shifts[$];
      logic [63:0] bests[$];
      int          counts[$];
      bit          seen[logic [63:0]];
      bit          tset[logic [63:0]];
      int          wcount, best, nb, c;
      bit          dropped;
      out_word_t   o;
      m = addr_mask();
      wcount = 0;
      dropped = 0;
      foreach (entries[i]) begin
        if (entries[i] < elo || entries[i] > ehi) continue;
        wcount++;
        foreach (targets[j]) begin
          if (targets[j] < tlo || targets[j] > thi) continue;
          d = (targets[j] - entries[i]) & m;
          if (seen.exists(d)) continue;
          if (shifts.size() >= SHIFT_DEPTH) begin
            dropped = 1;
            continue;
          end
          shifts.insert(shifts.size(), d);
          seen[d] = 1;
        end
      end
      o = '0;
      o.window_entry_count = wcount[8:0];
      o.candidates_dropped = dropped;
      if (shifts.size() == 0) begin
        o.result_kind = KIND_NONE;
        o.last_result = 1'b1;
        pending.insert(pending.size(), o);
        return;
      end
      foreach (targets[j]) tset[targets[j]] = 1;
      best = 0;
      foreach (shifts[s]) begin
        c = 0;
        foreach (entries[j]) if (tset.exists((entries[j] + shifts[s]) & m)) c++;
        counts.insert(counts.size(), c);
        if (c > best) best = c;
      end
      foreach (shifts[s]) if (counts[s] == best) bests.insert(bests.size(), shifts[s]);
      bests.sort();
      nb = bests.size();
      o.result_kind = KIND_BEST;
      o.match_count = best[8:0];
      o.report_truncated = nb > REPORT_LIMIT;
      for (int k = 0; k < nb && k < REPORT_LIMIT; k++) begin
        o.best_shift = bests[k];
        o.last_result = (k == nb - 1) || (k == REPORT_LIMIT - 1);
        pending.insert(pending.size(), o);
      end
    endfunction

    function void note(in_word_t w);
      bit dup;
      case (w.req_type)
        REQ_ENTRY, REQ_TARGET: begin
          dup = 0;
          if (w.req_type == REQ_ENTRY) begin
            foreach (entries[i]) if (entries[i] == w.address_value) dup = 1;
            if (dup) push_ack(ST_PRESENT);
            else if (entries.size() >= ENTRY_DEPTH) push_ack(ST_FULL);
            else begin
              entries.insert(entries.size(), w.address_value);
              push_ack(ST_INSERTED);
            end
          end else begin
            foreach (targets[i]) if (targets[i] == w.address_value) dup = 1;
            if (dup) push_ack(ST_PRESENT);
            else if (targets.size() >= TARGET_DEPTH) push_ack(ST_FULL);
            else begin
              targets.insert(targets.size(), w.address_value);
              push_ack(ST_INSERTED);
            end
          end
        end
        REQ_ANALYZE: run_analysis();
        default: begin
          entries.delete();
          targets.delete();
          push_ack(ST_INSERTED);
        end
      endcase
    endfunction

    function void check(out_word_t r);
      out_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.result_kind !== e.result_kind)
        $display("%0t: result_kind exp %0d got %0d", $time, e.result_kind, r.result_kind);
      if (r.load_status !== e.load_status)
        $display("%0t: load_status exp %0d got %0d", $time, e.load_status, r.load_status);
      if (r.best_shift !== e.best_shift)
        $display("%0t: best_shift exp %h got %h", $time, e.best_shift, r.best_shift);
      if (r.match_count !== e.match_count)
        $display("%0t: match_count exp %0d got %0d", $time, e.match_count, r.match_count);
      if (r.window_entry_count !== e.window_entry_count)
        $display("%0t: window_entry_count exp %0d got %0d", $time,
                 e.window_entry_count, r.window_entry_count);
      if (r.report_truncated !== e.report_truncated)
        $display("%0t: report_truncated exp %0d got %0d", $time,
                 e.report_truncated, r.report_truncated);
      if (r.candidates_dropped !== e.candidates_dropped)
        $display("%0t: candidates_dropped exp %0d got %0d", $time,
                 e.candidates_dropped, r.candidates_dropped);
      if (r.last_result !== e.last_result)
        $display("%0t: last_result exp %0d got %0d", $time, e.last_result, r.last_result);
      if (r !== e) errors++;
    endfunction
  endclass

  localparam int STALL_LIMIT = 40_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        result_valid;
  out_word_t   result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  rebase_scoreboard sb = new();
  int  words_sent = 0;
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;

  best_rebase_delta_finder i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note(in_word);
      if (result_valid) sb.check(result);
      if ((start && !busy) || result_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] req, logic [63:0] addr);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    forever begin
      @(negedge clk);
      if (busy) start <= 1'b0;
      else begin
        start <= 1'b1;
        in_word <= '{req_type: req, address_value: addr};
        break;
      end
    end
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_windows(logic [63:0] el, logic [63:0] eh,
                             logic [63:0] tl, logic [63:0] th);
    write_reg(CFG_ENTRY_LOW, el);
    write_reg(CFG_ENTRY_HIGH, eh);
    write_reg(CFG_TARGET_LOW, tl);
    write_reg(CFG_TARGET_HIGH, th);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] base, sh, a;
    logic [63:0] picks[$];
    int          ne, nt, choice;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send(REQ_ANALYZE, '1);
    send(REQ_ENTRY, 64'd0);
    send(REQ_ENTRY, '1);
    send(REQ_ENTRY, '1);
    send(REQ_ENTRY, 64'h0000_0001_0000_0010);
    send(REQ_TARGET, 64'h10);
    send(REQ_TARGET, 64'h20);
    send(REQ_TARGET, 64'h20);
    send(REQ_TARGET, 64'h8000_0000_0000_0000);
    send(REQ_ANALYZE, 64'd0);
    write_reg(CFG_ADDR_BITS, 64'd0);
    send(REQ_ANALYZE, 64'd0);
    write_reg(CFG_ADDR_BITS, 64'd64);
    send(REQ_ANALYZE, 64'd0);
    write_reg(CFG_ADDR_BITS, 64'd127);
    send(REQ_ANALYZE, 64'd0);
    set_windows(64'd5, 64'd4, 64'd0, '1);
    send(REQ_ANALYZE, 64'd0);
    set_windows(64'd0, '1, '1, '1);
    send(REQ_ANALYZE, 64'd0);
    send(REQ_CLEAR, rand64());
    send(REQ_ANALYZE, 64'd0);

    // fill both sets, narrow windows keep analysis short
    set_windows(64'd1000, 64'd1000, 64'd3000, 64'd3000);
    for (int i = 0; i <= ENTRY_DEPTH; i++) send(REQ_ENTRY, 64'd1000 + i);
    for (int i = 0; i <= TARGET_DEPTH; i++) send(REQ_TARGET, 64'd3000 + 2 * i);
    send(REQ_ENTRY, 64'd1000);
    send(REQ_ANALYZE, 64'd0);
    send(REQ_CLEAR, 64'd0);

    // overflow the candidate store with distinct pair differences
    set_windows(64'd0, '1, 64'd0, '1);
    for (int i = 0; i < 33; i++) send(REQ_ENTRY, 64'd1000 * i);
    for (int j = 0; j < 32; j++) send(REQ_TARGET, 64'd50000 + 7 * j);
    send(REQ_ANALYZE, 64'd0);
    send(REQ_CLEAR, 64'd0);

    while (words_sent < 660) begin
      if (words_sent > 620) gaps_on = 1'b0;
      choice = $urandom_range(0, 9);
      case (choice)
        0: write_reg(CFG_ADDR_BITS, 64'd1);
        1: write_reg(CFG_ADDR_BITS, 64'd8);
        2: write_reg(CFG_ADDR_BITS, 64'd63);
        3: write_reg(CFG_ADDR_BITS, 64'd65 + $urandom_range(0, 62));
        4: write_reg(CFG_ADDR_BITS, 64'd0);
        5: write_reg(CFG_ADDR_BITS, 64'd64);
        default: write_reg(CFG_ADDR_BITS, 64'($urandom_range(1, 64)));
      endcase
      base = rand64();
      if ($urandom_range(0, 3) == 0) base[63:56] = '1;
      sh = rand64();
      if ($urandom_range(0, 2) == 0) sh = 64'($urandom_range(0, 300));
      picks.delete();
      send(REQ_CLEAR, rand64());
      ne = $urandom_range(1, 10);
      for (int i = 0; i < ne; i++) begin
        a = base + $urandom_range(0, 4000);
        if ($urandom_range(0, 7) == 0) a = rand64();
        if (picks.size() != 0 && $urandom_range(0, 6) == 0) a = picks[0];
        picks.insert(picks.size(), a);
        send(REQ_ENTRY, a);
      end
      nt = $urandom_range(1, 10);
      for (int j = 0; j < nt; j++) begin
        a = picks[$urandom_range(0, picks.size() - 1)] + sh;
        if ($urandom_range(0, 3) == 0) a = rand64();
        if ($urandom_range(0, 8) == 0) a = sh + 64'($urandom_range(0, 4000));
        send(REQ_TARGET, a);
        if ($urandom_range(0, 9) == 0) send(REQ_TARGET, a);
      end
      if ($urandom_range(0, 2) == 0)
        set_windows(base + $urandom_range(0, 2000), base + $urandom_range(0, 4000),
                    base + sh + $urandom_range(0, 2000), $urandom_range(0, 4) == 0 ?
                    rand64() : '1);
      else if ($urandom_range(0, 1) == 0)
        set_windows(64'd0, '1, 64'd0, '1);
      send(REQ_ANALYZE, rand64());
      if ($urandom_range(0, 3) == 0) send(REQ_ANALYZE, 64'd0);
      if ($urandom_range(0, 5) == 0) send(2'($urandom_range(0, 3)), rand64());
    end

    drain();
    repeat (100) @(negedge clk);
    if (sb.pending.size() == 0 && sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
